// ===== src/prq_pkg.sv =====
// Shared types, constants and codes for the process ready queue.
`timescale 1ns / 1ps

package prq_pkg;

    // Default queue depth and fixed field widths
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int ID_W            = 10;
    localparam int PRIO_W          = 8;
    localparam int ENTRY_W         = ID_W + PRIO_W;
    localparam int S_DATA_W        = ((ID_W + PRIO_W + 7) / 8) * 8;

    // Item kind carried in s_tuser
    localparam logic ACT_ENQ = 1'b0;
    localparam logic ACT_DEQ = 1'b1;

    // Ordering mode register values
    localparam logic MODE_HEAP = 1'b0;
    localparam logic MODE_FIFO = 1'b1;

    // Result status carried in m_tuser
    typedef enum logic [1:0] {
        ST_ENQUEUED = 2'd0,
        ST_FULL     = 2'd1,
        ST_DEQUEUED = 2'd2,
        ST_EMPTY    = 2'd3
    } status_code_t;

    // Controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_FIFO_LD,
        S_UP_CHK,
        S_UP_CMP,
        S_DQ_LD,
        S_DN_CHK,
        S_DN_CMP,
        S_FINISH
    } ctrl_state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic         cap_in;      // capture the input transfer
        logic         set_status;  // load the result status
        status_code_t status_code;
        logic         fifo_wr;     // write entry at tail, advance tail
        logic         fifo_rd;     // read at head
        logic         fifo_ld;     // take head entry, advance head
        logic         up_init;     // hole at count, moving entry = input
        logic         up_rd;       // read parent of hole
        logic         up_move;     // parent into hole, hole moves up
        logic         place;       // moving entry into hole
        logic         dq_rd;       // read root and last entry
        logic         dq_ld;       // take root, moving entry = last
        logic         dn_rd;       // read both children of hole
        logic         dn_move;     // winning child into hole, hole moves down
        logic         load_out;    // load the result register
    } prq_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic action;    // kind of the captured item
        logic mode;      // ordering mode
        logic full;
        logic empty;
        logic pos_zero;  // hole is at the root
        logic up_less;   // moving entry beats its parent
        logic lc_out;    // left child lies beyond the held entries
        logic dn_swap;   // a child beats the moving entry
        logic out_busy;  // result register still holds an untaken result
    } prq_sts_t;

endpackage

// ===== src/process_ready_queue.sv =====
// Top level of the process ready queue: controller and datapath.
`timescale 1ns / 1ps

// Bounded ready queue of (process id, priority) entries, a binary min-heap on
// priority (lower first, left child wins ties) when ordering_mode is 0, or a
// FIFO ring when it is 1. One request is handled at a time and each gives one
// result transfer. A FIFO enqueue or a rejected request (full or empty) is
// settled in the decode state, and a FIFO dequeue then takes the head entry. A
// heap enqueue lets the entry rise towards the root, and a heap dequeue lets
// the last entry sink from the root. The entry moves at most log2(QUEUE_DEPTH)
// levels, and each level is one read of the entry memory, then a compare and
// a write. A result not yet taken holds the block in its last state. s_tready
// is high only while the block is idle, which it is from the cycle after the
// result is loaded. Write ordering_mode only while no request is in flight.

module process_ready_queue import prq_pkg::*; #(
    parameter  int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1),
    localparam int M_DATA_W    = ((ID_W + PRIO_W + CNT_W + 1 + 7) / 8) * 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    // Ordering mode register: 0 heap, 1 FIFO
    input  logic                cfg_wr_en,
    input  logic                cfg_wr_data,
    // Requests
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,  // proc_id[9:0], priority_req[17:10], zero pad
    input  logic                s_tuser,  // action: 0 enqueue, 1 dequeue
    // Results
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,  // out_proc_id, out_priority, entry_count,
                                          // is_empty, zero pad (lowest first)
    output logic [1:0]          m_tuser   // status
);

    prq_cmd_t cmd;
    prq_sts_t sts;

    prq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    prq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .cmd         (cmd),
        .sts         (sts),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule

// ===== src/prq_ctrl.sv =====
// Controller state machine of the process ready queue.
`timescale 1ns / 1ps

module prq_ctrl import prq_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  prq_sts_t sts,
    output prq_cmd_t cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.cap_in = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                cmd.set_status = 1'b1;
                if (sts.action == ACT_ENQ) begin
                    if (sts.full) begin
                        cmd.status_code = ST_FULL;
                        state_next      = S_FINISH;
                    end else if (sts.mode == MODE_FIFO) begin
                        cmd.status_code = ST_ENQUEUED;
                        cmd.fifo_wr     = 1'b1;
                        state_next      = S_FINISH;
                    end else begin
                        cmd.status_code = ST_ENQUEUED;
                        cmd.up_init     = 1'b1;
                        state_next      = S_UP_CHK;
                    end
                end else begin
                    if (sts.empty) begin
                        cmd.status_code = ST_EMPTY;
                        state_next      = S_FINISH;
                    end else if (sts.mode == MODE_FIFO) begin
                        cmd.status_code = ST_DEQUEUED;
                        cmd.fifo_rd     = 1'b1;
                        state_next      = S_FIFO_LD;
                    end else begin
                        cmd.status_code = ST_DEQUEUED;
                        cmd.dq_rd       = 1'b1;
                        state_next      = S_DQ_LD;
                    end
                end
            end
            S_FIFO_LD: begin
                cmd.fifo_ld = 1'b1;
                state_next  = S_FINISH;
            end
            S_UP_CHK: begin
                if (sts.pos_zero) begin
                    cmd.place  = 1'b1;
                    state_next = S_FINISH;
                end else begin
                    cmd.up_rd  = 1'b1;
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                if (sts.up_less) begin
                    cmd.up_move = 1'b1;
                    state_next  = S_UP_CHK;
                end else begin
                    cmd.place  = 1'b1;
                    state_next = S_FINISH;
                end
            end
            S_DQ_LD: begin
                cmd.dq_ld  = 1'b1;
                state_next = S_DN_CHK;
            end
            S_DN_CHK: begin
                if (sts.lc_out) begin
                    cmd.place  = 1'b1;
                    state_next = S_FINISH;
                end else begin
                    cmd.dn_rd  = 1'b1;
                    state_next = S_DN_CMP;
                end
            end
            S_DN_CMP: begin
                if (sts.dn_swap) begin
                    cmd.dn_move = 1'b1;
                    state_next  = S_DN_CHK;
                end else begin
                    cmd.place  = 1'b1;
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!sts.out_busy) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== src/prq_datapath.sv =====
// Datapath of the process ready queue: entry memory, pointers, sift registers, result register.
`timescale 1ns / 1ps

module prq_datapath import prq_pkg::*; #(
    parameter  int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    localparam int PTR_W       = $clog2(QUEUE_DEPTH),
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1),
    localparam int M_DATA_W    = ((ID_W + PRIO_W + CNT_W + 1 + 7) / 8) * 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic                cfg_wr_data,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic                s_tuser,
    input  prq_cmd_t            cmd,
    output prq_sts_t            sts,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,
    output logic [1:0]          m_tuser
);

    localparam int CHILD_W = CNT_W + 1;

    logic [ENTRY_W-1:0] mem [QUEUE_DEPTH];

    logic               mode_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [PTR_W-1:0]   head_reg;
    logic [PTR_W-1:0]   tail_reg;
    logic [PTR_W-1:0]   pos_reg;
    logic [ENTRY_W-1:0] cur_reg;
    logic               in_action_reg;
    logic [ENTRY_W-1:0] in_entry_reg;
    logic [ENTRY_W-1:0] removed_reg;
    status_code_t       status_reg;
    logic [ENTRY_W-1:0] rd0_reg;
    logic [ENTRY_W-1:0] rd1_reg;
    logic               m_tvalid_reg;
    logic [M_DATA_W-1:0] m_data_reg;
    logic [1:0]         m_user_reg;

    logic [PTR_W-1:0]   head_inc;
    logic [PTR_W-1:0]   tail_inc;
    logic [PTR_W-1:0]   par;
    logic [CHILD_W-1:0] lc_w;
    logic [CHILD_W-1:0] rc_w;
    logic [CHILD_W-1:0] cnt_w;
    logic               rc_ok;
    logic [PRIO_W-1:0]  cur_pri;
    logic [PRIO_W-1:0]  rd0_pri;
    logic [PRIO_W-1:0]  rd1_pri;
    logic               l_less;
    logic [PRIO_W-1:0]  best_pri;
    logic               r_win;
    logic [ENTRY_W-1:0] best_data;
    logic [PTR_W-1:0]   best_pos;
    logic               rd_en;
    logic [PTR_W-1:0]   rd_addr0;
    logic [PTR_W-1:0]   rd_addr1;
    logic               wr_en;
    logic [PTR_W-1:0]   wr_addr;
    logic [ENTRY_W-1:0] wr_data;

    // Ring pointer increments, wrapping at the depth
    assign head_inc = (head_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign tail_inc = (tail_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + 1'b1;

    // Heap neighbours of the hole
    assign par   = PTR_W'((pos_reg - 1'b1) >> 1);
    assign lc_w  = (CHILD_W'(pos_reg) << 1) + CHILD_W'(1);
    assign rc_w  = lc_w + CHILD_W'(1);
    assign cnt_w = CHILD_W'(count_reg);
    assign rc_ok = rc_w < cnt_w;

    // Priority compares; on a tie between children the left one wins
    assign cur_pri   = cur_reg[PRIO_W-1:0];
    assign rd0_pri   = rd0_reg[PRIO_W-1:0];
    assign rd1_pri   = rd1_reg[PRIO_W-1:0];
    assign l_less    = rd0_pri < cur_pri;
    assign best_pri  = l_less ? rd0_pri : cur_pri;
    assign r_win     = rc_ok && (rd1_pri < best_pri);
    assign best_data = r_win ? rd1_reg : rd0_reg;
    assign best_pos  = r_win ? PTR_W'(rc_w) : PTR_W'(lc_w);

    // Status to the controller
    always_comb begin
        sts.action   = in_action_reg;
        sts.mode     = mode_reg;
        sts.full     = count_reg == CNT_W'(QUEUE_DEPTH);
        sts.empty    = count_reg == '0;
        sts.pos_zero = pos_reg == '0;
        sts.up_less  = cur_pri < rd0_pri;
        sts.lc_out   = lc_w >= cnt_w;
        sts.dn_swap  = l_less || r_win;
        sts.out_busy = m_tvalid_reg && !m_tready;
    end

    // Memory read address selection
    always_comb begin
        rd_en    = cmd.fifo_rd | cmd.up_rd | cmd.dq_rd | cmd.dn_rd;
        rd_addr0 = '0;
        rd_addr1 = '0;
        if (cmd.fifo_rd) begin
            rd_addr0 = head_reg;
        end else if (cmd.up_rd) begin
            rd_addr0 = par;
        end else if (cmd.dq_rd) begin
            rd_addr1 = PTR_W'(count_reg - 1'b1);
        end else if (cmd.dn_rd) begin
            rd_addr0 = PTR_W'(lc_w);
            rd_addr1 = rc_ok ? PTR_W'(rc_w) : PTR_W'(lc_w);
        end
    end

    // Memory write selection
    always_comb begin
        wr_en   = cmd.fifo_wr | cmd.up_move | cmd.place | cmd.dn_move;
        wr_addr = pos_reg;
        wr_data = cur_reg;
        if (cmd.fifo_wr) begin
            wr_addr = tail_reg;
            wr_data = in_entry_reg;
        end else if (cmd.up_move) begin
            wr_data = rd0_reg;
        end else if (cmd.dn_move) begin
            wr_data = best_data;
        end
    end

    // Entry memory, registered reads
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd0_reg <= mem[rd_addr0];
            rd1_reg <= mem[rd_addr1];
        end
    end

    // Control state: mode, count and ring pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_HEAP;
            count_reg <= '0;
            head_reg  <= '0;
            tail_reg  <= '0;
        end else begin
            if (cfg_wr_en) begin
                mode_reg <= cfg_wr_data;
            end
            if (cmd.fifo_wr) begin
                tail_reg  <= tail_inc;
                count_reg <= count_reg + 1'b1;
            end else if (cmd.up_init) begin
                count_reg <= count_reg + 1'b1;
            end else if (cmd.fifo_ld) begin
                head_reg  <= head_inc;
                count_reg <= count_reg - 1'b1;
            end else if (cmd.dq_ld) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Item registers and sift state
    always_ff @(posedge aclk) begin
        if (cmd.cap_in) begin
            in_action_reg <= s_tuser;
            in_entry_reg  <= {s_tdata[ID_W-1:0], s_tdata[ID_W+PRIO_W-1:ID_W]};
            removed_reg   <= '0;
        end
        if (cmd.set_status) begin
            status_reg <= cmd.status_code;
        end
        if (cmd.up_init) begin
            cur_reg <= in_entry_reg;
            pos_reg <= PTR_W'(count_reg);
        end
        if (cmd.up_move) begin
            pos_reg <= par;
        end
        if (cmd.fifo_ld) begin
            removed_reg <= rd0_reg;
        end
        if (cmd.dq_ld) begin
            removed_reg <= rd0_reg;
            cur_reg     <= rd1_reg;
            pos_reg     <= '0;
        end
        if (cmd.dn_move) begin
            pos_reg <= best_pos;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_data_reg <= M_DATA_W'({(count_reg == '0), count_reg,
                                     removed_reg[PRIO_W-1:0],
                                     removed_reg[ENTRY_W-1:PRIO_W]});
            m_user_reg <= status_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule
